// ----- rtl/pollard_rho_dlog_walk_step_top_defines.svh -----
// assertion macros used by the checker file of the walk step block
// no dependencies
`ifndef POLLARD_RHO_DLOG_WALK_STEP_TOP_DEFINES_SVH
`define POLLARD_RHO_DLOG_WALK_STEP_TOP_DEFINES_SVH

// same-cycle implication, reset disables the check
`define PRDW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset disables the check
`define PRDW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/prdw_pkg.sv -----
// shared types and constants of the pollard rho walk step block
// no dependencies
package prdw_pkg;

  localparam int MOD_WIDTH = 64;
  localparam int PT_W      = 64;
  localparam int EXP_W     = 63;
  localparam int SER_STEPS = 64;
  localparam int CNT_W     = $clog2(SER_STEPS);

  localparam logic [PT_W-1:0] MOD_MASK = {PT_W{1'b1}} >> (PT_W - MOD_WIDTH);

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_MODULUS     = 2'd0,
    REG_GROUP_ORDER = 2'd1,
    REG_GENERATOR   = 2'd2,
    REG_TARGET_ELEM = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_ONE  = 2'd1,
    RES_TWO  = 2'd2
  } res_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SEED_WR,
    ST_EXP_UPD,
    ST_MUL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic reduce;
    logic seed_wr;
    logic exp_upd;
    logic mul_step;
    logic mul_last;
    logic out_load;
  } cmd_t;

endpackage

// ----- rtl/prdw_ctrl.sv -----
// sequencer of the walk step block: handshakes, phase counter, commands
// depends on prdw_pkg
module prdw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            opcode_i,
  input  logic            out_stall_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output prdw_pkg::cmd_t  cmd_o
);

  prdw_pkg::state_e             state_q, state_d;
  prdw_pkg::op_e                op_q, op_d;
  logic [prdw_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         cnt_done;
  logic                         out_free;

  assign cnt_done = (cnt_q == prdw_pkg::CNT_W'(prdw_pkg::SER_STEPS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prdw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = prdw_pkg::ST_REDUCE;
      end
      prdw_pkg::ST_REDUCE: begin
        if (cnt_done) begin
          state_d = (op_q == prdw_pkg::OP_SEED) ? prdw_pkg::ST_SEED_WR
                                                : prdw_pkg::ST_EXP_UPD;
        end
      end
      prdw_pkg::ST_SEED_WR: state_d = prdw_pkg::ST_FINISH;
      prdw_pkg::ST_EXP_UPD: state_d = prdw_pkg::ST_MUL;
      prdw_pkg::ST_MUL: begin
        if (cnt_done) state_d = prdw_pkg::ST_FINISH;
      end
      prdw_pkg::ST_FINISH: begin
        if (out_free) state_d = prdw_pkg::ST_IDLE;
      end
      default: state_d = prdw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == prdw_pkg::ST_IDLE) && in_valid_i;
    cmd_o.reduce   = (state_q == prdw_pkg::ST_REDUCE);
    cmd_o.seed_wr  = (state_q == prdw_pkg::ST_SEED_WR);
    cmd_o.exp_upd  = (state_q == prdw_pkg::ST_EXP_UPD);
    cmd_o.mul_step = (state_q == prdw_pkg::ST_MUL);
    cmd_o.mul_last = (state_q == prdw_pkg::ST_MUL) && cnt_done;
    cmd_o.out_load = (state_q == prdw_pkg::ST_FINISH) && out_free;
  end

  always_comb begin
    if ((state_q == prdw_pkg::ST_REDUCE || state_q == prdw_pkg::ST_MUL) && !cnt_done) begin
      cnt_d = cnt_q + prdw_pkg::CNT_W'(1);
    end else begin
      cnt_d = '0;
    end
    op_d = cmd_o.load ? prdw_pkg::op_e'(opcode_i) : op_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prdw_pkg::ST_IDLE;
      op_q        <= prdw_pkg::OP_SEED;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != prdw_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/prdw_dp.sv -----
// datapath of the walk step block: config registers, serial reducers,
// shift-add modular multiplier, walk state and result register
// depends on prdw_pkg
module prdw_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  prdw_pkg::cmd_t               cmd_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [prdw_pkg::PT_W-1:0]    cfg_data_i,
  input  logic                         opcode_i,
  input  logic [prdw_pkg::PT_W-1:0]    seed_point_i,
  input  logic [prdw_pkg::EXP_W-1:0]   seed_exp_gen_i,
  input  logic [prdw_pkg::EXP_W-1:0]   seed_exp_target_i,
  output logic [prdw_pkg::PT_W-1:0]    point_o,
  output logic [prdw_pkg::EXP_W-1:0]   exp_gen_o,
  output logic [prdw_pkg::EXP_W-1:0]   exp_target_o,
  output logic                         distinguished_o
);

  localparam int PW = prdw_pkg::PT_W;
  localparam int EW = prdw_pkg::EXP_W;

  // one restoring step of r = (2r + b) mod m, r < m
  function automatic logic [PW-1:0] red_step(logic [PW-1:0] r, logic b, logic [PW-1:0] m);
    logic [PW:0] t;
    t = {r, b};
    return (t >= {1'b0, m}) ? PW'(t - {1'b0, m}) : t[PW-1:0];
  endfunction

  // (a + b) mod m for a, b < m
  function automatic logic [EW-1:0] add_mod(logic [EW-1:0] a, logic [EW-1:0] b,
                                             logic [EW-1:0] m);
    logic [EW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, m}) ? EW'(s - {1'b0, m}) : s[EW-1:0];
  endfunction

  // config and walk state
  logic [PW-1:0] modulus_q, generator_q, target_elem_q;
  logic [EW-1:0] group_order_q;
  logic [PW-1:0] walk_point_q;
  logic [EW-1:0] walk_exp_gen_q, walk_exp_target_q;

  // reducer lanes: source shift registers and remainders
  logic [PW-1:0] pm_q;
  logic [EW-1:0] em_q;
  logic [PW-1:0] xs_q, gs_q, ts_q, as_q, bs_q;
  logic [PW-1:0] rx_q, rg_q, rt_q;
  logic [EW-1:0] ra_q, rb_q;
  logic [1:0]    r3_q;

  // multiplier
  logic [PW-1:0] acc_q, acc_d, ma_q, mb_q;

  logic [PW-1:0] pm_raw;
  logic [EW-1:0] em_one;
  logic [EW-1:0] a_new, b_new;
  logic [PW-1:0] ma_new;
  logic [PW+1:0] mt, mm1, mm2;
  logic [2:0]    t3;
  logic [10:0]   byte_sum;
  logic [8:0]    byte_fold;
  logic [PW-1:0] ra_ext, rb_ext;

  assign pm_raw = modulus_q & prdw_pkg::MOD_MASK;
  assign em_one = (em_q == EW'(1)) ? '0 : EW'(1);
  assign t3     = {r3_q, xs_q[PW-1]};
  assign ra_ext = red_step({1'b0, ra_q}, as_q[PW-1], {1'b0, em_q});
  assign rb_ext = red_step({1'b0, rb_q}, bs_q[PW-1], {1'b0, em_q});

  // exponent update and multiplicand choice by residue of the point
  always_comb begin
    a_new  = ra_q;
    b_new  = rb_q;
    ma_new = rg_q;
    unique case (prdw_pkg::res_e'(r3_q))
      prdw_pkg::RES_ONE: begin
        b_new  = add_mod(rb_q, em_one, em_q);
        ma_new = rt_q;
      end
      prdw_pkg::RES_ZERO: begin
        a_new  = add_mod(ra_q, ra_q, em_q);
        b_new  = add_mod(rb_q, rb_q, em_q);
        ma_new = rx_q;
      end
      default: begin
        a_new  = add_mod(ra_q, em_one, em_q);
        ma_new = rg_q;
      end
    endcase
  end

  // shift-add step: acc < m and ma < m keep 2acc + ma below 3m
  always_comb begin
    mt  = {1'b0, acc_q, 1'b0} + (mb_q[PW-1] ? {2'b00, ma_q} : '0);
    mm1 = mt - {2'b00, pm_q};
    mm2 = mt - {1'b0, pm_q, 1'b0};
    if (mt >= {1'b0, pm_q, 1'b0}) begin
      acc_d = mm2[PW-1:0];
    end else if (mt >= {2'b00, pm_q}) begin
      acc_d = mm1[PW-1:0];
    end else begin
      acc_d = mt[PW-1:0];
    end
  end

  // point mod 255 through the byte sum
  always_comb begin
    byte_sum = '0;
    for (int i = 0; i < PW / 8; i++) begin
      byte_sum = byte_sum + 11'(walk_point_q[8*i +: 8]);
    end
    byte_fold = {1'b0, byte_sum[7:0]} + 9'(byte_sum[10:8]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q         <= PW'(3);
      group_order_q     <= EW'(1);
      generator_q       <= PW'(1);
      target_elem_q     <= PW'(1);
      walk_point_q      <= '0;
      walk_exp_gen_q    <= '0;
      walk_exp_target_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (prdw_pkg::reg_idx_e'(cfg_idx_i))
          prdw_pkg::REG_MODULUS:     modulus_q     <= cfg_data_i;
          prdw_pkg::REG_GROUP_ORDER: group_order_q <= cfg_data_i[EW-1:0];
          prdw_pkg::REG_GENERATOR:   generator_q   <= cfg_data_i;
          prdw_pkg::REG_TARGET_ELEM: target_elem_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.seed_wr) begin
        walk_point_q      <= rx_q;
        walk_exp_gen_q    <= ra_q;
        walk_exp_target_q <= rb_q;
      end
      if (cmd_i.exp_upd) begin
        walk_exp_gen_q    <= a_new;
        walk_exp_target_q <= b_new;
      end
      if (cmd_i.mul_last) begin
        walk_point_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pm_q <= (pm_raw == '0) ? PW'(1) : pm_raw;
      em_q <= (group_order_q == '0) ? EW'(1) : group_order_q;
      if (prdw_pkg::op_e'(opcode_i) == prdw_pkg::OP_SEED) begin
        xs_q <= seed_point_i;
        as_q <= {1'b0, seed_exp_gen_i};
        bs_q <= {1'b0, seed_exp_target_i};
      end else begin
        xs_q <= walk_point_q;
        as_q <= {1'b0, walk_exp_gen_q};
        bs_q <= {1'b0, walk_exp_target_q};
      end
      gs_q <= generator_q;
      ts_q <= target_elem_q;
      rx_q <= '0;
      rg_q <= '0;
      rt_q <= '0;
      ra_q <= '0;
      rb_q <= '0;
      r3_q <= '0;
    end
    if (cmd_i.reduce) begin
      rx_q <= red_step(rx_q, xs_q[PW-1], pm_q);
      rg_q <= red_step(rg_q, gs_q[PW-1], pm_q);
      rt_q <= red_step(rt_q, ts_q[PW-1], pm_q);
      ra_q <= ra_ext[EW-1:0];
      rb_q <= rb_ext[EW-1:0];
      r3_q <= (t3 >= 3'd3) ? 2'(t3 - 3'd3) : t3[1:0];
      xs_q <= {xs_q[PW-2:0], 1'b0};
      gs_q <= {gs_q[PW-2:0], 1'b0};
      ts_q <= {ts_q[PW-2:0], 1'b0};
      as_q <= {as_q[PW-2:0], 1'b0};
      bs_q <= {bs_q[PW-2:0], 1'b0};
    end
    if (cmd_i.exp_upd) begin
      acc_q <= '0;
      ma_q  <= ma_new;
      mb_q  <= rx_q;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_d;
      mb_q  <= {mb_q[PW-2:0], 1'b0};
    end
    if (cmd_i.out_load) begin
      point_o         <= walk_point_q;
      exp_gen_o       <= walk_exp_gen_q;
      exp_target_o    <= walk_exp_target_q;
      distinguished_o <= (byte_fold == 9'd0) || (byte_fold == 9'd255);
    end
  end

endmodule

// ----- rtl/pollard_rho_dlog_walk_step_top.sv -----
// top level of the pollard rho discrete log walk step block
// depends on prdw_pkg, prdw_ctrl and prdw_dp
//
// one walk iteration per step transaction, with the point mod the modulus
// register and both exponents mod the group order register; a seed
// transaction reloads point and exponents reduced below their moduli, and
// every transaction returns exactly one result with the walk and a flag set
// when the point is a multiple of 255. the block works on one transaction
// at a time, paced by the bit-serial remainder pass (all operands reduced
// in parallel lanes) and, for a step, the shift-add modular multiplier. a
// finished result sits in an output register, so a new transaction is taken
// while the previous result is still stalled; configuration must be written
// only while the block is idle, which the block itself does not enforce
module pollard_rho_dlog_walk_step_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [prdw_pkg::PT_W-1:0]   cfg_data_i,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [prdw_pkg::PT_W-1:0]   seed_point_i,
  input  logic [prdw_pkg::EXP_W-1:0]  seed_exp_gen_i,
  input  logic [prdw_pkg::EXP_W-1:0]  seed_exp_target_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [prdw_pkg::PT_W-1:0]   point_o,
  output logic [prdw_pkg::EXP_W-1:0]  exp_gen_o,
  output logic [prdw_pkg::EXP_W-1:0]  exp_target_o,
  output logic                        distinguished_o
);

  // commands from the sequencer to the datapath
  prdw_pkg::cmd_t cmd;

  // sequencer: idle, reduce, seed write or exponent update plus multiply,
  // then hand the result to the output register once it is free
  prdw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // datapath: holds config, walk state and the result register
  prdw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .seed_point_i      (seed_point_i),
    .seed_exp_gen_i    (seed_exp_gen_i),
    .seed_exp_target_i (seed_exp_target_i),
    .point_o           (point_o),
    .exp_gen_o         (exp_gen_o),
    .exp_target_o      (exp_target_o),
    .distinguished_o   (distinguished_o)
  );

endmodule

// ----- rtl/prdw_checker.sv -----
// port-level checks of the walk step block, bound to the top level
// depends on prdw_pkg and the assertion macro header
`include "pollard_rho_dlog_walk_step_top_defines.svh"

module prdw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_i,
  input logic                        out_valid_i,
  input logic                        out_stall_i,
  input logic [prdw_pkg::PT_W-1:0]   point_i
);

  // a stalled result stays offered
  `PRDW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i, "result dropped while stalled")

  // a stalled result keeps its point
  `PRDW_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(point_i), "result point changed while stalled")

  // an accepted transaction keeps the input side busy in the next cycle
  `PRDW_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i, "input taken again right after a transaction")

  // a new result only appears while a transaction was in progress
  `PRDW_ASSERT_IMP(a_result_from_work, clk_i, rst_ni, $rose(out_valid_i), $past(in_stall_i), "result without work in progress")

endmodule

bind pollard_rho_dlog_walk_step_top prdw_checker u_prdw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .point_i     (point_o)
);

// ----- dv/pollard_rho_dlog_walk_step_top_tb.sv -----
// self-checking testbench of the pollard rho walk step block: directed and random
// seed/step transactions checked against a cycle-free walk predictor
// depends on prdw_pkg and pollard_rho_dlog_walk_step_top
module pollard_rho_dlog_walk_step_top_tb;
  import prdw_pkg::*;

  localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] P64   = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] point;
    logic [62:0] exp_gen;
    logic [62:0] exp_target;
    logic        distinguished;
  } walk_result_t;

  // keeps its own copy of the registers and the walk, and the walks still owed
  class walk_tracker;
    logic [63:0]  modulus_q, generator_q, target_q, point_q;
    logic [62:0]  order_q, exp_gen_q, exp_target_q;
    walk_result_t owed_walks[$];
    int           failures, seeds, steps, dist_hits;
    int           residue_hits[3];

    function new();
      modulus_q    = 64'd3;
      order_q      = 63'd1;
      generator_q  = 64'd1;
      target_q     = 64'd1;
      point_q      = '0;
      exp_gen_q    = '0;
      exp_target_q = '0;
      failures     = 0;
      seeds        = 0;
      steps        = 0;
      dist_hits    = 0;
      residue_hits = '{0, 0, 0};
    endfunction

    function void set_reg(reg_idx_e idx, logic [63:0] data);
      case (idx)
        REG_MODULUS:     modulus_q   = data;
        REG_GROUP_ORDER: order_q     = data[62:0];
        REG_GENERATOR:   generator_q = data;
        REG_TARGET_ELEM: target_q    = data;
        default: ;
      endcase
    endfunction

    // exact modular product through a double-width intermediate
    function logic [63:0] mod_product(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [127:0] prod;
      logic [127:0] rem;
      prod = {64'd0, x} * {64'd0, y};
      rem  = prod % {64'd0, m};
      return rem[63:0];
    endfunction

    function void accept_item(op_e op, logic [63:0] sp, logic [62:0] eg, logic [62:0] et);
      logic [63:0]  pm, em, a, b;
      walk_result_t r;
      pm = modulus_q & MOD_MASK;
      if (pm == 0) pm = 64'd1;
      em = {1'b0, order_q};
      if (em == 0) em = 64'd1;
      if (op == OP_SEED) begin
        seeds++;
        point_q = sp % pm;
        a = {1'b0, eg} % em;
        b = {1'b0, et} % em;
      end else begin
        steps++;
        a = {1'b0, exp_gen_q} % em;
        b = {1'b0, exp_target_q} % em;
        // partition on the stored point, before any reduction
        case (res_e'(2'(point_q % 3)))
          RES_ONE: begin
            residue_hits[1]++;
            point_q = mod_product(point_q, target_q, pm);
            b = (b + 64'd1) % em;
          end
          RES_ZERO: begin
            residue_hits[0]++;
            point_q = mod_product(point_q, point_q, pm);
            a = (a << 1) % em;
            b = (b << 1) % em;
          end
          default: begin
            residue_hits[2]++;
            point_q = mod_product(point_q, generator_q, pm);
            a = (a + 64'd1) % em;
          end
        endcase
      end
      exp_gen_q       = a[62:0];
      exp_target_q    = b[62:0];
      r.point         = point_q;
      r.exp_gen       = exp_gen_q;
      r.exp_target    = exp_target_q;
      r.distinguished = (point_q % 255 == 0);
      if (r.distinguished) dist_hits++;
      owed_walks.insert(owed_walks.size(), r);
    endfunction

    function void check_result(walk_result_t got);
      walk_result_t want;
      if (owed_walks.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual point %h", $time, got.point);
        return;
      end
      want = owed_walks.pop_front();
      if (got.point !== want.point) begin
        failures++;
        $display("%0t: point expected %h actual %h", $time, want.point, got.point);
      end
      if (got.exp_gen !== want.exp_gen) begin
        failures++;
        $display("%0t: exp_gen expected %h actual %h", $time, want.exp_gen, got.exp_gen);
      end
      if (got.exp_target !== want.exp_target) begin
        failures++;
        $display("%0t: exp_target expected %h actual %h", $time, want.exp_target,
                 got.exp_target);
      end
      if (got.distinguished !== want.distinguished) begin
        failures++;
        $display("%0t: distinguished expected %b actual %b", $time, want.distinguished,
                 got.distinguished);
      end
    endfunction

    function int owed();
      return owed_walks.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [PT_W-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                opcode_i;
  logic [PT_W-1:0]     seed_point_i;
  logic [EXP_W-1:0]    seed_exp_gen_i;
  logic [EXP_W-1:0]    seed_exp_target_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PT_W-1:0]     point_o;
  logic [EXP_W-1:0]    exp_gen_o;
  logic [EXP_W-1:0]    exp_target_o;
  logic                distinguished_o;

  walk_tracker tracker;
  int          burst_left = 0;
  int          settings_seen = 0;
  bit          hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  pollard_rho_dlog_walk_step_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .seed_point_i      (seed_point_i),
    .seed_exp_gen_i    (seed_exp_gen_i),
    .seed_exp_target_i (seed_exp_target_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .point_o           (point_o),
    .exp_gen_o         (exp_gen_o),
    .exp_target_o      (exp_target_o),
    .distinguished_o   (distinguished_o)
  );

  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  // zero, one, all ones, full random or a small value
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 4))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return ALL64;
      3:       return rand_wide();
      default: return 64'($urandom_range(2, 100000));
    endcase
  endfunction

  // called at a clock edge; one register per cycle
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  task automatic program_walk(input logic [63:0] m, input logic [63:0] order,
                              input logic [63:0] gen, input logic [63:0] tgt);
    write_reg(REG_MODULUS, m);
    write_reg(REG_GROUP_ORDER, order);
    write_reg(REG_GENERATOR, gen);
    write_reg(REG_TARGET_ELEM, tgt);
    cfg_we_i <= 1'b0;
    settings_seen++;
  endtask

  // offers one transaction and returns at the edge that accepts it; valid stays
  // up so the next call can continue the burst without a bubble
  task automatic send_item(input op_e op, input logic [63:0] sp, input logic [62:0] eg,
                           input logic [62:0] et);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= op;
    seed_point_i      <= sp;
    seed_exp_gen_i    <= eg;
    seed_exp_target_i <= et;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    tracker.accept_item(op, sp, eg, et);
  endtask

  // sender pauses until every owed walk is back, leaving the block idle
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tracker.owed() != 0) @(posedge clk_i);
  endtask

  // mostly steps so the walk runs long, seeds now and then to restart it
  task automatic random_item();
    logic [63:0] sp;
    logic [62:0] eg, et;
    case ($urandom_range(0, 3))
      0: begin
        sp = 64'($urandom_range(0, 2000));
        eg = 63'($urandom_range(0, 2000));
        et = 63'($urandom_range(0, 2000));
      end
      1: begin
        sp = ALL64;
        eg = MAX63;
        et = MAX63;
      end
      default: begin
        sp = rand_wide();
        eg = 63'(rand_wide());
        et = 63'(rand_wide());
      end
    endcase
    send_item(($urandom_range(0, 99) < 10) ? OP_SEED : OP_STEP, sp, eg, et);
  endtask

  // result side: check at each accepting edge, then pick the next stall value
  initial begin : result_sink
    int           mode, mode_left, hold_left;
    walk_result_t got;
    mode        = 0;
    mode_left   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {point_o, exp_gen_o, exp_target_o, distinguished_o};
        tracker.check_result(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 99) < 30);
          2:       out_stall_i <= ($urandom_range(0, 99) < 70);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [63:0] m, order;
    int          n;
    tracker           = new();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_MODULUS;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    opcode_i          = OP_SEED;
    seed_point_i      = '0;
    seed_exp_gen_i    = '0;
    seed_exp_target_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: step from the zero point, seeds at the field extremes
    send_item(OP_STEP, ALL64, MAX63, MAX63);
    send_item(OP_SEED, ALL64, MAX63, MAX63);
    send_item(OP_SEED, 64'd2, 63'd0, 63'd0);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    finish_phase();

    // large prime, largest order, generator and target above the modulus
    program_walk(P64, ALL64, ALL64, P64 + 64'd5);
    send_item(OP_SEED, 64'd1, MAX63 - 63'd1, MAX63 - 63'd1);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    send_item(OP_SEED, P64 - 64'd1, 63'h4000_0000_0000_0000, 63'h2AAA_AAAA_AAAA_AAAA);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    // squaring with both exponents doubling past the order
    send_item(OP_SEED, 64'd3, 63'h4000_0000_0000_0005, MAX63 - 63'd1);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    send_item(OP_SEED, 64'd2, MAX63 - 63'd1, 63'd0);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    send_item(OP_SEED, 64'd255000, 63'd0, 63'd0);
    send_item(OP_SEED, ALL64, MAX63, MAX63);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    finish_phase();

    // small modulus: the leftover point must be reduced before use
    program_walk(64'd1019, 64'd1000, 64'd5, 64'd7);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    finish_phase();

    // zero modulus and zero order behave as one
    program_walk(64'd0, 64'd0, 64'd5, 64'd7);
    send_item(OP_SEED, rand_wide(), 63'(rand_wide()), 63'(rand_wide()));
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    finish_phase();

    // modulus one; order with only bit 63 set masks to zero
    program_walk(64'd1, 64'h8000_0000_0000_0000, ALL64, ALL64);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    send_item(OP_SEED, ALL64, MAX63, MAX63);
    send_item(OP_STEP, 64'd0, 63'd0, 63'd0);
    finish_phase();

    // random phases, the first two at the register extremes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        m     = ALL64;
        order = ALL64;
      end else if (ph == 1) begin
        m     = 64'd3;
        order = 64'd1;
      end else begin
        case ($urandom_range(0, 5))
          0:       m = ALL64;
          1:       m = P64;
          2: begin
            case ($urandom_range(0, 3))
              0:       m = 64'd257;
              1:       m = 64'd1019;
              2:       m = 64'd65521;
              default: m = 64'd2147483647;
            endcase
          end
          3:       m = rand_wide() | 64'd1;
          4:       m = (rand_wide() >> $urandom_range(8, 60)) | 64'd3;
          default: m = 64'd3;
        endcase
        case ($urandom_range(0, 3))
          0:       order = ALL64;
          1:       order = 64'($urandom_range(1, 5000));
          2:       order = rand_wide();
          default: order = rand_wide() >> $urandom_range(8, 60);
        endcase
      end
      program_walk(m, order, rand_operand(), rand_operand());
      n = $urandom_range(65, 80);
      for (int i = 0; i < n; i++) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 2 && i == 10) hold_req = 1'b1;
        random_item();
      end
      finish_phase();
    end

    // trailing window for any result that should not come
    repeat (150) @(posedge clk_i);
    $display("run covered %0d seeds and %0d steps (residue 0/1/2: %0d/%0d/%0d)",
             tracker.seeds, tracker.steps, tracker.residue_hits[0],
             tracker.residue_hits[1], tracker.residue_hits[2]);
    $display("over %0d register settings, %0d distinguished points, %0d walks not returned",
             settings_seen, tracker.dist_hits, tracker.owed());
    if (tracker.failures == 0 && tracker.owed() == 0) begin
      $display("pollard_rho_dlog_walk_step_top: match");
    end else begin
      $display("pollard_rho_dlog_walk_step_top: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("pollard_rho_dlog_walk_step_top: mismatch");
    $finish;
  end

endmodule

// ----- pollard_rho_dlog_walk_step_top.f -----
+incdir+rtl
rtl/prdw_pkg.sv
rtl/prdw_ctrl.sv
rtl/prdw_dp.sv
rtl/pollard_rho_dlog_walk_step_top.sv
rtl/prdw_checker.sv
dv/pollard_rho_dlog_walk_step_top_tb.sv
